FILE: rtl/core/cdt_gaussian_sampler_defines.svh
// Assertion macros for the CDT Gaussian sampler.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CDT_GAUSSIAN_SAMPLER_DEFINES_SVH
`define CDT_GAUSSIAN_SAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cdt_pkg.sv
// Shared types and constants for the CDT Gaussian sampler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cdt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int FRAC_BITS   = 48;
  localparam int ENTRY_W     = FRAC_BITS + 1;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 9;
  localparam int SAMPLE_W    = 9;
  localparam int MAG_W       = 8;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } cdt_state_t;

  // Commands from the controller to the datapath and the output register.
  typedef struct packed {
    logic wr_en;
    logic start;
    logic rd_en;
    logic step;
    logic load_out;
  } cdt_cmd_t;

  typedef struct packed {
    logic done;
  } cdt_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/cdt_ctrl.sv
// Controller state machine for the CDT Gaussian sampler.
// Depends on cdt_pkg; drives the datapath through cdt_cmd_t.
`default_nettype none

module cdt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_func,
  output logic                   in_stall,
  input  wire logic              out_free,
  input  wire cdt_pkg::cdt_sts_t sts,
  output cdt_pkg::cdt_cmd_t      cmd
);
  import cdt_pkg::*;

  cdt_state_t state_r;
  cdt_state_t state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_LOAD)) begin
          cmd.wr_en = 1'b1;
        end
        if (accept && (in_func == FUNC_SAMPLE)) begin
          // Entry 0 is fetched at the accepting edge.
          cmd.start = 1'b1;
          cmd.rd_en = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.done) begin
          // Hold the scan position until the output register has room.
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          cmd.step  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdt_dp.sv
// Datapath for the CDT Gaussian sampler: table memory, scan position,
// compare and sample forming. Depends on cdt_pkg.
`default_nettype none

module cdt_dp (
  input  wire logic                          clk,
  input  wire cdt_pkg::cdt_cmd_t             cmd,
  output cdt_pkg::cdt_sts_t                  sts,
  input  wire logic [cdt_pkg::ADDR_W-1:0]    entry_index,
  input  wire logic [cdt_pkg::ENTRY_W-1:0]   entry_value,
  input  wire logic [cdt_pkg::FRAC_BITS-1:0] uniform_value,
  input  wire logic                          sign_bit,
  input  wire logic [cdt_pkg::LEN_W-1:0]     table_length,
  output logic signed [cdt_pkg::SAMPLE_W-1:0] sample
);
  import cdt_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(TABLE_DEPTH);
  localparam logic [LEN_W-1:0] MAG_MAX   = LEN_W'((1 << MAG_W) - 1);

  logic [ENTRY_W-1:0]   mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic [LEN_W-1:0]     pos_r;
  logic [LEN_W-1:0]     pos_inc;
  logic [FRAC_BITS-1:0] u_r;
  logic                 neg_r;
  logic [LEN_W-1:0]     len_eff;
  logic                 hit;
  logic                 past_end;
  logic [LEN_W-1:0]     mag_wide;
  logic [MAG_W-1:0]     mag;

  assign pos_inc = pos_r + LEN_W'(1);
  // The next entry is fetched while the current one is compared.
  assign rd_addr = cmd.start ? '0 : pos_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[entry_index] <= entry_value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos_r <= '0;
      u_r   <= uniform_value;
      neg_r <= sign_bit;
    end else if (cmd.step) begin
      pos_r <= pos_inc;
    end
  end

  assign len_eff  = (table_length > DEPTH_LEN) ? DEPTH_LEN : table_length;
  assign hit      = rd_data_r > {1'b0, u_r};
  assign past_end = pos_r >= len_eff;
  assign sts.done = past_end || hit;

  // At completion pos_r is the first entry above u, or the searched length.
  always_comb begin
    mag_wide = (pos_r == '0) ? '0 : pos_r - LEN_W'(1);
    mag      = (mag_wide > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : mag_wide[MAG_W-1:0];
    if (neg_r && (mag != '0)) begin
      sample = -$signed({1'b0, mag});
    end else begin
      sample = $signed({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdt_gaussian_sampler.sv
// Top level of the CDT Gaussian sampler: length register, output register
// and assertions. Depends on cdt_pkg, cdt_ctrl, cdt_dp and the defines header.
`default_nettype none

// Usage:
// The input channel (in_valid / in_stall) carries one beat per item. A beat
// with in_func low writes in_entry_value into table entry in_entry_index and
// gives no result. A beat with in_func high draws one sample from
// in_uniform_value and in_sign_bit and gives one beat on the output channel
// (out_valid / out_stall) with out_sample.
// The table is scanned linearly from entry 0, one entry per cycle through the
// registered read port of the table memory, until the search stops at index
// i (the first entry above the uniform value, or table_length capped at 256);
// the sample is then registered at the output, and the next beat is taken
// in the cycle after that. in_stall is high while a sample is being searched.
// The cfg channel (cfg_valid / cfg_ready, always ready) writes table_length.
// Reset sets table_length to 256, empties the output register and returns
// the controller to idle; table contents stay undefined until written.
// When the receiver stalls, the finished sample waits in the output register;
// a new beat is still accepted, and its search holds at completion until the
// output register is free.
module cdt_gaussian_sampler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic [7:0]                     in_entry_index,
  input  wire logic [cdt_pkg::ENTRY_W-1:0]    in_entry_value,
  input  wire logic [cdt_pkg::FRAC_BITS-1:0]  in_uniform_value,
  input  wire logic                           in_sign_bit,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [cdt_pkg::SAMPLE_W-1:0] out_sample,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cdt_pkg::LEN_W-1:0]      cfg_data
);
  import cdt_pkg::*;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

  cdt_cmd_t                   cmd;
  cdt_sts_t                   sts;
  logic [LEN_W-1:0]           table_length_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SAMPLE_W-1:0] dp_sample;
  logic                       out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      table_length_r <= cfg_data;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  cdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdt_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .entry_index   (in_entry_index[ADDR_W-1:0]),
    .entry_value   (in_entry_value),
    .uniform_value (in_uniform_value),
    .sign_bit      (in_sign_bit),
    .table_length  (table_length_r),
    .sample        (dp_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= dp_sample;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

`include "cdt_gaussian_sampler_defines.svh"

  `CDT_ASSERT_IMPL(a_load_needs_room, cmd.load_out, out_free, "result loaded over a waiting beat")
  `CDT_ASSERT_NEXT(a_sample_scans, in_valid && !in_stall && in_func == FUNC_SAMPLE, in_stall, "sample beat did not start a scan")
  `CDT_ASSERT_IMPL(a_no_min_code, out_valid_r, out_sample_r != -256, "sample magnitude out of range")
  `CDT_ASSERT_IMPL(a_write_idle, cmd.wr_en, !in_stall && !cmd.rd_en, "table write outside idle")

endmodule

`default_nettype wire

FILE: sim/cdt_gaussian_sampler_test.sv
// Self-checking testbench for the CDT Gaussian sampler: table loads, table length writes and
// sample draws, with random sender bursts and receiver stalls.
// Depends on cdt_pkg and cdt_gaussian_sampler.
module cdt_gaussian_sampler_test;
  import cdt_pkg::*;

  localparam logic [ENTRY_W-1:0]   PROB_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] UNIFORM_MAX = {FRAC_BITS{1'b1}};

  typedef struct {
    logic                 func;
    logic [7:0]           index;
    logic [ENTRY_W-1:0]   value;
    logic [FRAC_BITS-1:0] uniform;
    logic                 sign;
  } cdt_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_func = FUNC_LOAD;
  logic [7:0] in_entry_index = '0;
  logic [ENTRY_W-1:0] in_entry_value = '0;
  logic [FRAC_BITS-1:0] in_uniform_value = '0;
  logic in_sign_bit = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  logic cfg_ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  cdt_gaussian_sampler DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_uniform_value (in_uniform_value),
    .in_sign_bit      (in_sign_bit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Beats waiting to be driven, and the samples predicted for accepted draws.
  cdt_beat_t pending_beats[$];
  logic [SAMPLE_W-1:0] expected_samples[$];
  int fail_count = 0;

  // Predictor state: a private copy of the table and of the search length.
  logic [ENTRY_W-1:0] model_table [TABLE_DEPTH];
  logic [LEN_W-1:0]   model_length = LEN_W'(256);

  // Stimulus-side copy of the table, used only to aim uniform values at entries.
  logic [ENTRY_W-1:0] gen_table [TABLE_DEPTH];
  int gen_length = 256;

  function automatic logic [SAMPLE_W-1:0] draw_expected(logic [FRAC_BITS-1:0] u, logic neg);
    int unsigned len;
    int unsigned pos;
    int unsigned mag;
    logic [SAMPLE_W-1:0] result;
    len = (model_length > TABLE_DEPTH) ? TABLE_DEPTH : model_length;
    pos = 0;
    while (pos < len && model_table[pos] <= {1'b0, u})
      pos++;
    mag = (pos == 0) ? 0 : pos - 1;
    if (mag > 255)
      mag = 255;
    result = SAMPLE_W'(mag);
    if (neg && mag != 0)
      result = -result;
    return result;
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                 input logic [SAMPLE_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch: %s, expected %0d (%h), got %0d (%h)", what, $signed(want), want,
               $signed(got), got);
  endtask

  // Monitor and predictor.
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      model_length = LEN_W'(256);
    end else begin
      if (cfg_valid && cfg_ready)
        model_length = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample beat with no draw pending", 'x, out_sample);
        end else begin
          want = expected_samples.pop_front();
          if (want !== out_sample)
            report_mismatch("sample", want, out_sample);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_LOAD)
          model_table[in_entry_index] = in_entry_value;
        else
          expected_samples.push_back(draw_expected(in_uniform_value, in_sign_bit));
      end
    end
  end

  // Driver: bursts of beats separated by random gaps.
  logic [7:0] burst_left = '0;
  logic [7:0] gap_left = '0;

  always @(posedge clk) begin
    cdt_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= '0;
      gap_left <= '0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0 || pending_beats.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0)
          gap_left <= gap_left - 8'd1;
      end else begin
        nxt = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_func <= nxt.func;
        in_entry_index <= nxt.index;
        in_entry_value <= nxt.value;
        in_uniform_value <= nxt.uniform;
        in_sign_bit <= nxt.sign;
        if (burst_left <= 1) begin
          burst_left <= 8'($urandom_range(1, 16));
          gap_left <= ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
        end else begin
          burst_left <= burst_left - 8'd1;
        end
      end
    end
  end

  // Receiver: cycles through no stalls, light stalls, heavy stalls and long stall runs.
  logic [9:0] stall_count = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_count <= '0;
    end else begin
      stall_count <= stall_count + 10'd1;
      case (stall_count[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (stall_count[3:0] < 4'd11);
      endcase
    end
  end

  function automatic logic [FRAC_BITS-1:0] random_uniform();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [ENTRY_W-1:0] random_entry();
    return ($urandom_range(0, 15) == 0) ? PROB_ONE : {1'b0, random_uniform()};
  endfunction

  // Every beat starts with random index, value, uniform and sign fields so that the ignored fields carry noise too.
  function automatic cdt_beat_t random_beat();
    cdt_beat_t b;
    b.func = FUNC_LOAD;
    b.index = 8'($urandom);
    b.value = random_entry();
    b.uniform = random_uniform();
    b.sign = 1'($urandom_range(0, 1));
    return b;
  endfunction

  task automatic queue_load(input int idx, input logic [ENTRY_W-1:0] v);
    cdt_beat_t b;
    b = random_beat();
    b.func = FUNC_LOAD;
    b.index = 8'(idx);
    b.value = v;
    gen_table[idx] = v;
    pending_beats.push_back(b);
  endtask

  task automatic queue_draw(input logic [FRAC_BITS-1:0] u, input logic neg);
    cdt_beat_t b;
    b = random_beat();
    b.func = FUNC_SAMPLE;
    b.uniform = u;
    b.sign = neg;
    pending_beats.push_back(b);
  endtask

  // Loads entries 0..count-1 with a nondecreasing table that reaches one near index width.
  task automatic queue_shape(input int count, input int width);
    longint unsigned step;
    longint unsigned v;
    longint unsigned prev;
    step = (64'd1 << FRAC_BITS) / width;
    prev = 0;
    for (int i = 0; i < count; i++) begin
      v = step * i + ((step * $urandom_range(1, 255)) >> 8);
      if (i > 0 && $urandom_range(0, 7) == 0)
        v = prev;
      if (v > PROB_ONE)
        v = PROB_ONE;
      queue_load(i, ENTRY_W'(v));
      prev = v;
    end
  endtask

  function automatic logic [FRAC_BITS-1:0] clamp_uniform(logic [ENTRY_W-1:0] v);
    return (v >= PROB_ONE) ? UNIFORM_MAX : v[FRAC_BITS-1:0];
  endfunction

  // Uniform values, random or aimed at the entries in use, so that equality and near misses occur.
  function automatic logic [FRAC_BITS-1:0] pick_uniform();
    int k;
    int mode;
    k = $urandom_range(0, gen_length - 1);
    mode = $urandom_range(0, 9);
    if (mode < 4)
      return random_uniform();
    if (mode < 7)
      return clamp_uniform(gen_table[k]);
    if (mode < 9)
      return (gen_table[k] == 0) ? '0 : clamp_uniform(gen_table[k] - 1);
    if ($urandom_range(0, 1) == 0)
      return FRAC_BITS'($urandom_range(0, 255));
    return UNIFORM_MAX - FRAC_BITS'($urandom_range(0, 255));
  endfunction

  // Waits until every queued beat is accepted and every sample has come back.
  task automatic settle();
    while (pending_beats.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(input int len);
    cfg_valid <= 1'b1;
    cfg_data <= LEN_W'(len);
    do
      @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    gen_length = len;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_length(256);

    // The whole table stays below one, so a draw near one searches all 256 entries.
    queue_shape(256, 300);
    queue_draw('0, 1'b0);
    queue_draw('0, 1'b1);
    queue_draw(UNIFORM_MAX, 1'b0);
    queue_draw(UNIFORM_MAX, 1'b1);
    queue_draw(clamp_uniform(gen_table[5]), 1'b1);
    queue_draw(clamp_uniform(gen_table[5] - 1), 1'b0);
    // Zero entries at the front push the search past them.
    queue_load(0, '0);
    queue_draw('0, 1'b0);
    queue_load(1, '0);
    queue_draw('0, 1'b1);
    // An entry of exactly one stops every search there; a later zero breaks the order.
    queue_load(3, PROB_ONE);
    queue_draw(UNIFORM_MAX, 1'b1);
    queue_load(255, PROB_ONE);
    queue_load(3, '0);
    queue_draw(UNIFORM_MAX, 1'b0);
    queue_draw(clamp_uniform(gen_table[2]), 1'b1);

    for (int p = 0; p < 11; p++) begin
      int len;
      int fill;
      if (p == 0)
        len = 2;
      else if (p == 1 || p == 2)
        len = 256;
      else if (p == 3)
        len = 255;
      else if ($urandom_range(0, 3) == 0)
        len = $urandom_range(41, 256);
      else
        len = $urandom_range(2, 40);
      settle();
      write_length(len);
      if (p == 1 || (p != 2 && $urandom_range(0, 1) == 0)) begin
        fill = (len < 64) ? len : 64;
        queue_shape(fill, $urandom_range(1, fill + 4));
      end
      queue_draw(UNIFORM_MAX, 1'b1);
      queue_draw(UNIFORM_MAX, 1'b0);
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 3) == 0)
          queue_load($urandom_range(0, TABLE_DEPTH - 1), random_entry());
        else
          queue_draw(pick_uniform(), 1'($urandom_range(0, 1)));
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cdt_pkg.sv
rtl/core/cdt_ctrl.sv
rtl/core/cdt_dp.sv
rtl/core/cdt_gaussian_sampler.sv
sim/cdt_gaussian_sampler_test.sv
